// ===== hw/rtl/sdk_pkg.sv =====
// Shared widths, constants and types for the sidechain ducker.
// No dependencies; every other file in hw/rtl imports this package.
`default_nettype none

package sdk_pkg;

    // Field widths
    localparam int SAMPLE_W   = 18;
    localparam int AMOUNT_W   = 18;
    localparam int COEF_W     = 25;
    localparam int LEVEL_W    = 42;
    localparam int FRAC_W     = 24;
    localparam int GAIN_W     = 17;

    // Digit-serial multiplier geometry
    localparam int DIGIT_W    = 4;
    localparam int MUL_A_W    = 44;
    localparam int MUL_B_W    = 28;
    localparam int MUL_SUM_W  = MUL_A_W + DIGIT_W;
    localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
    localparam int MUL_DIGITS = MUL_B_W / DIGIT_W;
    localparam int MUL_CNT_W  = 3;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 25;

    localparam logic [CFG_IDX_W-1:0] CFG_DUCK_AMOUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_COEF  = 1'd1;

    // Reset values and limits
    localparam logic [AMOUNT_W-1:0] AMOUNT_RST = 18'd65536;
    localparam logic [AMOUNT_W-1:0] AMOUNT_MAX = 18'd131072;
    localparam logic [COEF_W-1:0]   COEF_RST   = 25'd699;
    localparam logic [COEF_W-1:0]   COEF_ONE   = 25'd16777216;
    localparam logic [GAIN_W-1:0]   GAIN_ONE   = 17'd65536;

    // Frame sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECAY,
        ST_DECAY_WAIT,
        ST_GAIN,
        ST_GAIN_WAIT,
        ST_FADE,
        ST_FADE_WAIT,
        ST_HOLD
    } t_state;

endpackage

`default_nettype wire

// ===== hw/rtl/sdk_in_if.sv =====
// Input channel: one stereo frame of over and under samples per transaction.
// Depends on sdk_pkg for the sample width.
`default_nettype none

interface sdk_in_if import sdk_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] over_left;
    logic signed [SAMPLE_W-1:0] over_right;
    logic signed [SAMPLE_W-1:0] under_left;
    logic signed [SAMPLE_W-1:0] under_right;

    modport source (output valid, output over_left, output over_right,
                    output under_left, output under_right, input ready);
    modport sink   (input valid, input over_left, input over_right,
                    input under_left, input under_right, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/sdk_out_if.sv =====
// Output channel: one ducked stereo frame per transaction.
// Depends on sdk_pkg for the sample width.
`default_nettype none

interface sdk_out_if import sdk_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] out_left;
    logic signed [SAMPLE_W-1:0] out_right;

    modport source (output valid, output out_left, output out_right, input ready);
    modport sink   (input valid, input out_left, input out_right, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/sdk_serial_mul.sv =====
// Digit-serial multiplier: signed multiplicand times unsigned multiplier,
// one 4-bit digit of the multiplier per cycle. Depends on sdk_pkg.
`default_nettype none

module sdk_serial_mul import sdk_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic signed [MUL_A_W-1:0] i_a,
    input  logic        [MUL_B_W-1:0] i_b,
    output logic                      o_done,
    output logic        [MUL_P_W-1:0] o_product
);

    logic signed [MUL_A_W-1:0]   r_a;
    logic        [MUL_B_W-1:0]   r_b;
    logic signed [MUL_A_W-1:0]   r_acc;
    logic        [MUL_B_W-1:0]   r_low;
    logic        [MUL_CNT_W-1:0] r_cnt, n_cnt;
    logic                        r_busy, n_busy;
    logic                        r_done, n_done;

    logic signed [DIGIT_W:0]     w_dig;
    logic signed [MUL_SUM_W-1:0] w_part;
    logic signed [MUL_SUM_W-1:0] w_sum;

    // Partial product of the lowest remaining digit, added to the running sum
    assign w_dig  = $signed({1'b0, r_b[DIGIT_W-1:0]});
    assign w_part = MUL_SUM_W'(r_a) * MUL_SUM_W'(w_dig);
    assign w_sum  = MUL_SUM_W'(r_acc) + w_part;

    // Digit counter and completion flag
    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_done = 1'b0;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = MUL_CNT_W'(MUL_DIGITS);
        end else if (r_busy) begin
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == MUL_CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // Load operands, then shift one digit per cycle: the high part stays in
    // r_acc, finished low bits drop into r_low from the top
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
            r_low <= '0;
        end else if (r_busy) begin
            r_b   <= r_b >> DIGIT_W;
            r_acc <= w_sum[MUL_SUM_W-1:DIGIT_W];
            r_low <= {w_sum[DIGIT_W-1:0], r_low[MUL_B_W-1:DIGIT_W]};
        end
    end

    assign o_done    = r_done;
    assign o_product = {r_acc, r_low};

endmodule

`default_nettype wire

// ===== hw/rtl/sidechain_ducker_core.sv =====
// Stereo sidechain ducker with a peak envelope follower.
// A new frame is accepted only in the idle state, once the previous frame's
// result has been taken into the output register. Three passes of the 7-digit
// serial multipliers (decay, gain, crossfade) run in series for each frame.
// Reset (synchronous, active low) clears the envelope, the sequencer and the
// output valid flag, and loads the default amount and decay coefficient.
// Depends on sdk_pkg, sdk_in_if, sdk_out_if and sdk_serial_mul.
`default_nettype none

module sidechain_ducker_core import sdk_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    sdk_in_if.sink                i_in,
    sdk_out_if.source             o_out
);

    t_state r_state, n_state;

    logic [AMOUNT_W-1:0] r_amount;
    logic [COEF_W-1:0]   r_coef;

    logic signed [SAMPLE_W-1:0] r_ol, r_or, r_ul, r_ur;
    logic [LEVEL_W-1:0]         r_level;
    logic [LEVEL_W-1:0]         r_peakq;
    logic                       r_snap;
    logic [GAIN_W-1:0]          r_g;

    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_left, r_out_right;

    // Sequencer outputs
    logic w_in_ready, w_start0, w_start1, w_peak_we, w_level_we, w_gain_we, w_out_we;
    logic w_out_free;

    // Multiplier ports
    logic signed [MUL_A_W-1:0] w_a0, w_a1;
    logic        [MUL_B_W-1:0] w_b0, w_b1;
    logic                      w_done0, w_done1;
    logic        [MUL_P_W-1:0] w_p0, w_p1;

    // Datapath helpers
    logic [SAMPLE_W-1:0]        w_mag_l, w_mag_r, w_peak;
    logic [LEVEL_W-1:0]         w_peakq;
    logic signed [MUL_A_W-1:0]  w_diff;
    logic [AMOUNT_W-1:0]        w_amt;
    logic [COEF_W-1:0]          w_coef;
    logic [GAIN_W-1:0]          w_f;
    logic [GAIN_W-1:0]          w_g;
    logic signed [SAMPLE_W:0]   w_dl, w_dr;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amount <= AMOUNT_RST;
            r_coef   <= COEF_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DUCK_AMOUNT: r_amount <= i_cfg_data[AMOUNT_W-1:0];
                CFG_DECAY_COEF:  r_coef   <= i_cfg_data[COEF_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp amount to 2.0 and coefficient to 1.0
    assign w_amt  = (r_amount > AMOUNT_MAX) ? AMOUNT_MAX : r_amount;
    assign w_coef = (r_coef > COEF_ONE) ? COEF_ONE : r_coef;

    // Peak of the sidechain pair, exact for the most negative sample
    assign w_mag_l = r_ol[SAMPLE_W-1] ? SAMPLE_W'(-r_ol) : SAMPLE_W'(r_ol);
    assign w_mag_r = r_or[SAMPLE_W-1] ? SAMPLE_W'(-r_or) : SAMPLE_W'(r_or);
    assign w_peak  = (w_mag_l > w_mag_r) ? w_mag_l : w_mag_r;
    assign w_peakq = {w_peak, FRAC_W'(0)};
    assign w_diff  = $signed({2'b00, r_level}) - $signed({2'b00, w_peakq});

    // Follower value, Q16, clamped to one
    assign w_f = (r_level[LEVEL_W-1:FRAC_W] > SAMPLE_W'(GAIN_ONE)) ? GAIN_ONE
               : r_level[FRAC_W+GAIN_W-1:FRAC_W];

    // Gain from f * amount^2 / 2^32, clamped to one
    assign w_g = (w_p0[MUL_P_W-1:32] > (MUL_P_W-32)'(GAIN_ONE)) ? GAIN_ONE
               : w_p0[32+GAIN_W-1:32];

    // Crossfade spans
    assign w_dl = $signed({r_ol[SAMPLE_W-1], r_ol}) - $signed({r_ul[SAMPLE_W-1], r_ul});
    assign w_dr = $signed({r_or[SAMPLE_W-1], r_or}) - $signed({r_ur[SAMPLE_W-1], r_ur});

    // Operand select for the two multipliers by phase
    always_comb begin
        w_a0 = MUL_A_W'(w_dl);
        w_b0 = MUL_B_W'(r_g);
        w_a1 = MUL_A_W'(w_dr);
        w_b1 = MUL_B_W'(r_g);
        case (r_state)
            ST_DECAY: begin
                w_a0 = w_diff;
                w_b0 = MUL_B_W'(w_coef);
                w_a1 = $signed(MUL_A_W'(w_amt));
                w_b1 = MUL_B_W'(w_amt);
            end
            ST_GAIN: begin
                w_a0 = $signed(MUL_A_W'(w_p1[2*AMOUNT_W-1:0]));
                w_b0 = MUL_B_W'(w_f);
            end
            default: ;
        endcase
    end

    sdk_serial_mul u_mul0 (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_start0),
        .i_a       (w_a0),
        .i_b       (w_b0),
        .o_done    (w_done0),
        .o_product (w_p0)
    );

    sdk_serial_mul u_mul1 (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_start1),
        .i_a       (w_a1),
        .i_b       (w_b1),
        .o_done    (w_done1),
        .o_product (w_p1)
    );

    assign w_out_free = !r_out_valid || o_out.ready;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:       if (i_in.valid) n_state = ST_DECAY;
            ST_DECAY:      n_state = ST_DECAY_WAIT;
            ST_DECAY_WAIT: if (w_done0 && w_done1) n_state = ST_GAIN;
            ST_GAIN:       n_state = ST_GAIN_WAIT;
            ST_GAIN_WAIT:  if (w_done0) n_state = ST_FADE;
            ST_FADE:       n_state = ST_FADE_WAIT;
            ST_FADE_WAIT: begin
                if (w_done0 && w_done1) n_state = w_out_free ? ST_IDLE : ST_HOLD;
            end
            ST_HOLD:       if (w_out_free) n_state = ST_IDLE;
            default:       n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        w_in_ready = 1'b0;
        w_start0   = 1'b0;
        w_start1   = 1'b0;
        w_peak_we  = 1'b0;
        w_level_we = 1'b0;
        w_gain_we  = 1'b0;
        w_out_we   = 1'b0;
        unique case (r_state)
            ST_IDLE:       w_in_ready = 1'b1;
            ST_DECAY: begin
                w_start0  = 1'b1;
                w_start1  = 1'b1;
                w_peak_we = 1'b1;
            end
            ST_DECAY_WAIT: w_level_we = w_done0 && w_done1;
            ST_GAIN:       w_start0 = 1'b1;
            ST_GAIN_WAIT:  w_gain_we = w_done0;
            ST_FADE: begin
                w_start0 = 1'b1;
                w_start1 = 1'b1;
            end
            ST_FADE_WAIT:  w_out_we = w_done0 && w_done1 && w_out_free;
            ST_HOLD:       w_out_we = w_out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_level     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            // Jump to the peak, or decay by floor(diff * coef / 2^24)
            if (w_level_we) begin
                r_level <= r_snap ? r_peakq
                         : r_level - w_p0[FRAC_W+LEVEL_W-1:FRAC_W];
            end
            if (w_out_we) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Frame capture and per-frame intermediates
    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_in.valid) begin
            r_ol <= i_in.over_left;
            r_or <= i_in.over_right;
            r_ul <= i_in.under_left;
            r_ur <= i_in.under_right;
        end
        if (w_peak_we) begin
            r_peakq <= w_peakq;
            r_snap  <= (w_peakq >= r_level);
        end
        if (w_gain_we) begin
            r_g <= w_g;
        end
        // under + floor(span * gain / 2^16), taken modulo the sample width
        if (w_out_we) begin
            r_out_left  <= r_ul + $signed(w_p0[16+SAMPLE_W-1:16]);
            r_out_right <= r_ur + $signed(w_p1[16+SAMPLE_W-1:16]);
        end
    end

    assign i_in.ready      = w_in_ready;
    assign o_out.valid     = r_out_valid;
    assign o_out.out_left  = r_out_left;
    assign o_out.out_right = r_out_right;

endmodule

`default_nettype wire
